### sv/vsp_pkg.sv
// Shared types, constants and helpers of the vertex screen projection block.
// No dependencies; imported by every module of the block.
package vsp_pkg;

  localparam int FracBitsDef   = 16;
  localparam int ScreenBitsDef = 18;
  localparam int StoreDepth    = 24;
  localparam int CoefW         = 32;
  localparam int VpW           = 16;
  localparam int CfgIdxW       = 2;
  localparam int IdxW          = 5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEFT   = 2'd0,
    CFG_TOP    = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_POINT = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic [IdxW-1:0]          coef_index;
    logic signed [CoefW-1:0]  coef_value;
    logic signed [CoefW-1:0]  point_x;
    logic signed [CoefW-1:0]  point_y;
    logic signed [CoefW-1:0]  point_z;
  } item_t;

  typedef struct packed {
    logic [VpW-1:0] left;
    logic [VpW-1:0] top;
    logic [VpW-1:0] width;
    logic [VpW-1:0] height;
  } viewport_t;

  function automatic logic signed [CoefW-1:0] sat32(input logic signed [67:0] v);
    logic signed [CoefW-1:0] r;
    if (v > 68'sh7FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < 68'shF_FFFF_FFFF_8000_0000) begin
      r = 32'sh80000000;
    end else begin
      r = v[CoefW-1:0];
    end
    return r;
  endfunction

endpackage

### sv/vsp_front.sv
// Front end: accepts items and queues them in order for the back end.
// Depends on vsp_pkg.
module vsp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  vsp_pkg::item_t item_i,
  output logic           busy_o,
  output logic           head_vld_o,
  output vsp_pkg::item_t head_o,
  input  logic           pop_i
);
  import vsp_pkg::*;

  item_t      mem_q [2];
  logic       rd_q, rd_d, wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign busy_o     = (cnt_q == 2'd2);
  assign head_vld_o = (cnt_q != 2'd0);
  assign head_o     = mem_q[rd_q];
  assign push       = start_i && !busy_o;
  assign pop        = pop_i && head_vld_o;

  always_comb begin
    rd_d  = pop  ? !rd_q : rd_q;
    wr_d  = push ? !wr_q : wr_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |=> cnt_q <= 2'd1)
    else $error("queue grew by more than one item");
  a_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 && !start_i) |=> !head_vld_o)
    else $error("item appeared without a push");

endmodule

### sv/vsp_div.sv
// Pipelined restoring divider, one quotient bit per stage, quotient clamped.
// Depends on vsp_pkg.
module vsp_div #(
  parameter int NW = 52,
  parameter int DW = 34,
  parameter int QW = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_vld_i,
  input  logic                 in_tag_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [DW-1:0] den_i,
  output logic                 out_vld_o,
  output logic                 out_tag_o,
  output logic signed [QW:0]   quot_o
);
  import vsp_pkg::*;

  logic [NW-1:0] amag_q;
  logic [DW-1:0] adiv_q;
  logic          aneg_q, avld_q, atag_q;

  logic [DW-1:0] rem_q [QW+1];
  logic [QW-1:0] nlo_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic          neg_q [QW+1];
  logic          ovf_q [QW+1];
  logic          vld_q [QW+1];
  logic          tag_q [QW+1];

  logic [QW-1:0] qmag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avld_q   <= 1'b0;
      vld_q[0] <= 1'b0;
    end else begin
      avld_q   <= in_vld_i;
      vld_q[0] <= avld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    amag_q   <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    adiv_q   <= den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
    aneg_q   <= num_i[NW-1] ^ den_i[DW-1];
    atag_q   <= in_tag_i;
    rem_q[0] <= DW'(amag_q[NW-1:QW]);
    nlo_q[0] <= amag_q[QW-1:0];
    quo_q[0] <= '0;
    den_q[0] <= adiv_q;
    neg_q[0] <= aneg_q;
    ovf_q[0] <= DW'(amag_q[NW-1:QW]) >= adiv_q;
    tag_q[0] <= atag_q;
  end

  for (genvar i = 1; i <= QW; i++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem_q[i-1], nlo_q[i-1][QW-i]};
    assign ge    = trial >= {1'b0, den_q[i-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i] <= ge ? DW'(trial - {1'b0, den_q[i-1]}) : trial[DW-1:0];
      nlo_q[i] <= nlo_q[i-1];
      quo_q[i] <= {quo_q[i-1][QW-2:0], ge};
      den_q[i] <= den_q[i-1];
      neg_q[i] <= neg_q[i-1];
      ovf_q[i] <= ovf_q[i-1];
      tag_q[i] <= tag_q[i-1];
    end
  end

  assign qmag      = ovf_q[QW] ? '1 : quo_q[QW];
  assign quot_o    = neg_q[QW] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign out_vld_o = vld_q[QW];
  assign out_tag_o = tag_q[QW];

endmodule

### sv/vsp_back.sv
// Back end: coefficient store, modelview and projection pipeline, viewport map.
// Depends on vsp_pkg and vsp_div.
module vsp_back #(
  parameter int FRAC_BITS   = vsp_pkg::FracBitsDef,
  parameter int SCREEN_BITS = vsp_pkg::ScreenBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_vld_i,
  input  vsp_pkg::item_t                head_i,
  output logic                          pop_o,
  input  vsp_pkg::viewport_t            vp_i,
  output logic                          done_o,
  output logic signed [SCREEN_BITS-1:0] screen_x_o,
  output logic signed [SCREEN_BITS-1:0] screen_y_o,
  output logic                          w_zero_o,
  output logic                          saturated_o
);
  import vsp_pkg::*;

  localparam int QW = ((SCREEN_BITS > 17) ? SCREEN_BITS : 17) + 2;
  localparam int NW = 52;
  localparam int DW = 34;
  localparam logic signed [63:0] SatHi = (64'sd1 <<< (SCREEN_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] SatLo = -(64'sd1 <<< (SCREEN_BITS - 1));

  logic signed [CoefW-1:0] store_q [StoreDepth];
  logic signed [CoefW-1:0] pt [3];

  logic signed [63:0]      mv_prod_q [12];
  logic signed [CoefW-1:0] m3_q [4];
  logic signed [CoefW-1:0] proj1_q [8];
  logic                    v1_q;

  logic signed [CoefW-1:0] eye_d [4];
  logic signed [CoefW-1:0] eye_q [4];
  logic signed [CoefW-1:0] proj2_q [8];
  logic                    v2_q, wz2_q;

  logic signed [63:0]      cp_q [8];
  logic signed [32:0]      w3_q;
  logic                    v3_q, wz3_q;

  logic signed [67:0]      csx, csy;
  logic signed [CoefW-1:0] cx_q, cy_q;
  logic signed [32:0]      w4_q;
  logic                    v4_q, wz4_q;

  logic signed [DW-1:0]    ax, ay, dd;
  logic signed [50:0]      nxa_q, nxb_q, nya_q, nyb_q;
  logic signed [DW-1:0]    d5_q, d6_q;
  logic                    v5_q, wz5_q, v6_q, wz6_q;
  logic signed [NW-1:0]    nx_q, ny_q;

  logic                    dx_vld, dy_vld, dx_tag, dy_tag;
  logic signed [QW:0]      qx, qy;
  logic signed [63:0]      sx64, sy64;
  logic                    cx_hi, cx_lo, cy_hi, cy_lo;

  logic                          done_q;
  logic signed [SCREEN_BITS-1:0] sx_q, sy_q;
  logic                          wz_q, sat_q;

  assign pop_o = head_vld_i;
  assign pt[0] = head_i.point_x;
  assign pt[1] = head_i.point_y;
  assign pt[2] = head_i.point_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StoreDepth; i++) begin
        store_q[i] <= '0;
      end
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (head_vld_i && head_i.kind == KIND_LOAD &&
          head_i.coef_index < IdxW'(StoreDepth)) begin
        store_q[head_i.coef_index] <= head_i.coef_value;
      end
      v1_q   <= head_vld_i && head_i.kind == KIND_POINT;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      done_q <= dx_vld;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      eye_d[r] = sat32(((68'(mv_prod_q[3*r]) + 68'(mv_prod_q[3*r+1])
                         + 68'(mv_prod_q[3*r+2])) >>> FRAC_BITS) + 68'(m3_q[r]));
    end
    csx = (68'(cp_q[0]) + 68'(cp_q[1]) + 68'(cp_q[2]) + 68'(cp_q[3])) >>> FRAC_BITS;
    csy = (68'(cp_q[4]) + 68'(cp_q[5]) + 68'(cp_q[6]) + 68'(cp_q[7])) >>> FRAC_BITS;
    ax  = DW'(cx_q) + DW'(w4_q);
    ay  = DW'(cy_q) + DW'(w4_q);
    dd  = {w4_q, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        mv_prod_q[3*r+c] <= pt[c] * store_q[4*r+c];
      end
      m3_q[r] <= store_q[4*r+3];
    end
    for (int j = 0; j < 8; j++) begin
      proj1_q[j] <= store_q[16+j];
      proj2_q[j] <= proj1_q[j];
      cp_q[j]    <= eye_q[j%4] * proj2_q[j];
    end
    for (int r = 0; r < 4; r++) begin
      eye_q[r] <= eye_d[r];
    end
    wz2_q <= (eye_d[2] == '0);
    w3_q  <= -(33'(eye_q[2]));
    wz3_q <= wz2_q;
    cx_q  <= sat32(csx);
    cy_q  <= sat32(csy);
    w4_q  <= w3_q;
    wz4_q <= wz3_q;
    nxa_q <= ax * $signed({1'b0, vp_i.width});
    nxb_q <= dd * $signed({1'b0, vp_i.left});
    nya_q <= ay * $signed({1'b0, vp_i.height});
    nyb_q <= dd * $signed({1'b0, vp_i.top});
    d5_q  <= dd;
    wz5_q <= wz4_q;
    nx_q  <= NW'(nxa_q) + NW'(nxb_q);
    ny_q  <= NW'(nya_q) + NW'(nyb_q);
    d6_q  <= d5_q;
    wz6_q <= wz5_q;
  end

  vsp_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (v6_q),
    .in_tag_i  (wz6_q),
    .num_i     (nx_q),
    .den_i     (d6_q),
    .out_vld_o (dx_vld),
    .out_tag_o (dx_tag),
    .quot_o    (qx)
  );

  vsp_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (v6_q),
    .in_tag_i  (wz6_q),
    .num_i     (ny_q),
    .den_i     (d6_q),
    .out_vld_o (dy_vld),
    .out_tag_o (dy_tag),
    .quot_o    (qy)
  );

  always_comb begin
    sx64  = 64'(qx);
    sy64  = 64'($signed({1'b0, vp_i.height})) - 64'(qy);
    cx_hi = sx64 > SatHi;
    cx_lo = sx64 < SatLo;
    cy_hi = sy64 > SatHi;
    cy_lo = sy64 < SatLo;
  end

  always_ff @(posedge clk_i) begin
    wz_q <= dx_tag;
    if (dx_tag) begin
      sx_q  <= '0;
      sy_q  <= '0;
      sat_q <= 1'b0;
    end else begin
      sx_q  <= cx_hi ? SatHi[SCREEN_BITS-1:0] :
               cx_lo ? SatLo[SCREEN_BITS-1:0] : sx64[SCREEN_BITS-1:0];
      sy_q  <= cy_hi ? SatHi[SCREEN_BITS-1:0] :
               cy_lo ? SatLo[SCREEN_BITS-1:0] : sy64[SCREEN_BITS-1:0];
      sat_q <= cx_hi || cx_lo || cy_hi || cy_lo;
    end
  end

  assign done_o      = done_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;
  assign w_zero_o    = wz_q;
  assign saturated_o = sat_q;

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dx_vld == dy_vld && (!dx_vld || dx_tag == dy_tag))
    else $error("divider lanes out of step");
  a_wzero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && w_zero_o |-> screen_x_o == '0 && screen_y_o == '0 && !saturated_o)
    else $error("zero w result carries data");
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && saturated_o |->
      screen_x_o == SatHi[SCREEN_BITS-1:0] || screen_x_o == SatLo[SCREEN_BITS-1:0] ||
      screen_y_o == SatHi[SCREEN_BITS-1:0] || screen_y_o == SatLo[SCREEN_BITS-1:0])
    else $error("saturation flag without a clamped coordinate");

endmodule

### sv/vertex_screen_projection.sv
// Top level of the vertex screen projection block: ports and viewport registers.
// Depends on vsp_pkg, vsp_front and vsp_back.
//
// One item is taken per clock while busy_o is low. A load item writes one
// coefficient (index below 24; higher indices are ignored) and gives no
// result; a point item gives one result on done_o, after the input queue,
// the transform registers and a divider with max(SCREEN_BITS, 17) + 2 bit
// stages, one quotient bit each. Results stay in order and must be taken in
// the cycle they appear; busy_o stays low in normal use.
module vertex_screen_projection #(
  parameter int FRAC_BITS   = vsp_pkg::FracBitsDef,
  parameter int SCREEN_BITS = vsp_pkg::ScreenBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                kind_i,
  input  logic [vsp_pkg::IdxW-1:0]            coef_index_i,
  input  logic signed [vsp_pkg::CoefW-1:0]    coef_value_i,
  input  logic signed [vsp_pkg::CoefW-1:0]    point_x_i,
  input  logic signed [vsp_pkg::CoefW-1:0]    point_y_i,
  input  logic signed [vsp_pkg::CoefW-1:0]    point_z_i,
  input  logic                                cfg_we_i,
  input  logic [vsp_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [vsp_pkg::VpW-1:0]             cfg_wdata_i,
  output logic                                done_o,
  output logic signed [SCREEN_BITS-1:0]       screen_x_o,
  output logic signed [SCREEN_BITS-1:0]       screen_y_o,
  output logic                                w_zero_o,
  output logic                                saturated_o
);
  import vsp_pkg::*;

  viewport_t vp_q;
  item_t     item, head;
  logic      head_vld, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q.left   <= VpW'(0);
      vp_q.top    <= VpW'(0);
      vp_q.width  <= VpW'(640);
      vp_q.height <= VpW'(480);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_LEFT:   vp_q.left   <= cfg_wdata_i;
        CFG_TOP:    vp_q.top    <= cfg_wdata_i;
        CFG_WIDTH:  vp_q.width  <= cfg_wdata_i;
        CFG_HEIGHT: vp_q.height <= cfg_wdata_i;
        default:    vp_q        <= vp_q;
      endcase
    end
  end

  always_comb begin
    item.kind       = kind_e'(kind_i);
    item.coef_index = coef_index_i;
    item.coef_value = coef_value_i;
    item.point_x    = point_x_i;
    item.point_y    = point_y_i;
    item.point_z    = point_z_i;
  end

  vsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item),
    .busy_o     (busy_o),
    .head_vld_o (head_vld),
    .head_o     (head),
    .pop_i      (pop)
  );

  vsp_back #(.FRAC_BITS(FRAC_BITS), .SCREEN_BITS(SCREEN_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_vld_i  (head_vld),
    .head_i      (head),
    .pop_o       (pop),
    .vp_i        (vp_q),
    .done_o      (done_o),
    .screen_x_o  (screen_x_o),
    .screen_y_o  (screen_y_o),
    .w_zero_o    (w_zero_o),
    .saturated_o (saturated_o)
  );

endmodule
